### rtl/adx_nsc_pkg.sv
// Shared types and constants for the ADX block nibble scaler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package adx_nsc_pkg;

    localparam int unsigned  BYTE_W      = 8;
    localparam int unsigned  SAMPLE_W    = 16;
    localparam int unsigned  POS_W       = 5;
    localparam int unsigned  HDR_CNT_W   = 17;

    // input op codes
    localparam logic         OP_BYTE     = 1'b0;
    localparam logic         OP_RESTART  = 1'b1;

    // channel_count value that selects stereo
    localparam logic [1:0]   MODE_STEREO = 2'd2;
    localparam logic [1:0]   MODE_RESET  = 2'd1;

    // block layout
    localparam logic [POS_W-1:0]     POS_SCALE_HI   = 5'd0;
    localparam logic [POS_W-1:0]     POS_SCALE_LO   = 5'd1;
    localparam logic [POS_W-1:0]     POS_FIRST_DATA = 5'd2;
    localparam logic [POS_W-1:0]     POS_LAST       = 5'd17;

    // header layout
    localparam logic [HDR_CNT_W-1:0] HDR_OFS_HI     = 17'd2;
    localparam logic [HDR_CNT_W-1:0] HDR_OFS_LO     = 17'd3;
    localparam logic [HDR_CNT_W-1:0] HDR_MIN_START  = 17'd4;

    localparam logic [2:0]   SCALE_ROUND = 3'b111;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

    // one data byte on its way to the sample stage
    typedef struct packed {
        logic [3:0]                 hi_nib;
        logic [3:0]                 lo_nib;
        logic signed [SAMPLE_W-1:0] factor;
        logic                       channel;
        logic                       last;
    } rec_t;

endpackage

`default_nettype wire

### rtl/adx_nsc_ctrl.sv
// Stream parser: header skip, block position, scale capture and channel.
// Depends on adx_nsc_pkg; hands one data-byte record at a time to adx_nsc_scale.
`default_nettype none

module adx_nsc_ctrl
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [1:0]                    channel_count,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          op,
    input  wire logic [adx_nsc_pkg::BYTE_W-1:0] byte_value,
    output logic                               rec_valid,
    output adx_nsc_pkg::rec_t                  rec,
    input  wire logic                          rec_take
);
    import adx_nsc_pkg::*;

    logic                       pending_reg, pending_next;
    logic [HDR_CNT_W-1:0]       hdr_count_reg, hdr_count_next;
    logic [15:0]                hdr_offset_reg, hdr_offset_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic                       chan_reg, chan_next;
    logic [15:0]                scale_reg, scale_next;
    logic                       rec_valid_reg, rec_valid_next;
    rec_t                       rec_reg, rec_next;

    logic                       accept;
    logic                       load_rec;
    logic                       block_byte;
    logic                       header_skip;
    logic [HDR_CNT_W-1:0]       data_start;

    assign in_stall  = rec_valid_reg && !rec_take;
    assign accept    = in_valid && !in_stall;
    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

    // a negative offset never pulls the data start below the minimum
    assign data_start  = {1'b0, hdr_offset_reg} + HDR_MIN_START;
    assign header_skip = (hdr_count_reg < HDR_MIN_START)
                      || (!hdr_offset_reg[15] && (hdr_count_reg < data_start));

    always_comb
    begin
        pending_next    = pending_reg;
        hdr_count_next  = hdr_count_reg;
        hdr_offset_next = hdr_offset_reg;
        pos_next        = pos_reg;
        chan_next       = chan_reg;
        scale_next      = scale_reg;
        load_rec        = 1'b0;
        block_byte      = 1'b0;
        rec_next        = rec_reg;

        if (accept)
        begin
            if (op == OP_RESTART)
            begin
                pending_next    = 1'b1;
                hdr_count_next  = '0;
                hdr_offset_next = '0;
                pos_next        = POS_SCALE_HI;
                chan_next       = 1'b0;
                scale_next      = '0;
            end
            else
            begin
                block_byte = 1'b1;
                if (pending_reg)
                begin
                    if (header_skip)
                    begin
                        block_byte     = 1'b0;
                        hdr_count_next = hdr_count_reg + 1'b1;
                        if (hdr_count_reg == HDR_OFS_HI)
                            hdr_offset_next = {byte_value, hdr_offset_reg[7:0]};
                        if (hdr_count_reg == HDR_OFS_LO)
                            hdr_offset_next = {hdr_offset_reg[15:8], byte_value};
                    end
                    else
                    begin
                        pending_next = 1'b0;
                    end
                end

                if (block_byte)
                begin
                    case (pos_reg)
                        POS_SCALE_HI:
                        begin
                            scale_next = {byte_value, scale_reg[7:0]};
                            pos_next   = POS_SCALE_LO;
                        end
                        POS_SCALE_LO:
                        begin
                            scale_next = {scale_reg[15:8], byte_value};
                            pos_next   = POS_FIRST_DATA;
                        end
                        default:
                        begin
                            load_rec         = 1'b1;
                            rec_next.hi_nib  = byte_value[7:4];
                            rec_next.lo_nib  = byte_value[3:0];
                            rec_next.factor  = {scale_reg[12:0], SCALE_ROUND};
                            rec_next.channel = chan_reg;
                            rec_next.last    = (pos_reg >= POS_LAST);
                            if (pos_reg >= POS_LAST)
                            begin
                                pos_next  = POS_SCALE_HI;
                                chan_next = (channel_count == MODE_STEREO) && !chan_reg;
                            end
                            else
                            begin
                                pos_next = pos_reg + 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        rec_valid_next = rec_valid_reg;
        if (load_rec)
            rec_valid_next = 1'b1;
        else if (rec_take)
            rec_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 1'b0;
            hdr_count_reg  <= '0;
            hdr_offset_reg <= '0;
            pos_reg        <= '0;
            chan_reg       <= 1'b0;
            scale_reg      <= '0;
            rec_valid_reg  <= 1'b0;
        end
        else
        begin
            pending_reg    <= pending_next;
            hdr_count_reg  <= hdr_count_next;
            hdr_offset_reg <= hdr_offset_next;
            pos_reg        <= pos_next;
            chan_reg       <= chan_next;
            scale_reg      <= scale_next;
            rec_valid_reg  <= rec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rec)
            rec_reg <= rec_next;
    end

endmodule

`default_nettype wire

### rtl/adx_nsc_scale.sv
// Sample stage: splits a data-byte record into two nibbles, scales and saturates each.
// Depends on adx_nsc_pkg; fed by adx_nsc_ctrl, drives the result register.
`default_nettype none

module adx_nsc_scale
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 rec_valid,
    input  wire adx_nsc_pkg::rec_t                    rec,
    output logic                                      rec_take,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [adx_nsc_pkg::SAMPLE_W-1:0]   sample,
    output logic                                      channel,
    output logic                                      last_in_block
);
    import adx_nsc_pkg::*;

    logic                       phase_reg, phase_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                       channel_reg;
    logic                       last_reg;

    logic                       out_free;
    logic                       advance;
    logic signed [3:0]          nib;
    logic signed [19:0]         prod;
    logic signed [16:0]         doubled;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = rec_valid && out_free;
    // release the record once its low nibble goes out
    assign rec_take = advance && phase_reg;

    // high nibble first
    assign nib     = phase_reg ? signed'(rec.lo_nib) : signed'(rec.hi_nib);
    // (n*4096*s) >> 16 equals (n*s) >> 4
    assign prod    = 20'(nib) * 20'(rec.factor);
    assign doubled = {prod[19:4], 1'b0};

    always_comb
    begin
        if (doubled[16] != doubled[15])
            sample_next = doubled[16] ? SAMPLE_MIN : SAMPLE_MAX;
        else
            sample_next = doubled[15:0];
    end

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            phase_next     = !phase_reg;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sample_reg  <= sample_next;
            channel_reg <= rec.channel;
            last_reg    <= phase_reg && rec.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample        = sample_reg;
    assign channel       = channel_reg;
    assign last_in_block = last_reg;

endmodule

`default_nettype wire

### rtl/adx_block_nibble_scaler_top.sv
// Top level of the ADX block nibble scaler: mode register, parser and sample stage.
// Depends on adx_nsc_pkg, adx_nsc_ctrl and adx_nsc_scale.
//
//  channel   handshake               payload
//  -------   ---------------------   ------------------------------------
//  input     in_valid / in_stall     op, byte_value
//  output    out_valid / out_stall   sample, channel, last_in_block
//  config    channel_count_we        channel_count_wdata
//
// Restart, header and scale bytes give no result. A data byte gives two
// samples, one per cycle on the output unless out_stall holds them; the next
// data byte is taken as the second sample is released. Samples pass through
// the record register, then the result register, which sets the byte rate.
// Reset clears all stream state and sets mono; no clearing pass is needed.
// A stall on the output holds the result register and backs up into in_stall.
`default_nettype none

module adx_block_nibble_scaler_top
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 channel_count_we,
    input  wire logic [1:0]                           channel_count_wdata,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 op,
    input  wire logic [adx_nsc_pkg::BYTE_W-1:0]       byte_value,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [adx_nsc_pkg::SAMPLE_W-1:0]   sample,
    output logic                                      channel,
    output logic                                      last_in_block
);
    import adx_nsc_pkg::*;

    logic [1:0] channel_count_reg;
    logic       rec_valid;
    logic       rec_take;
    rec_t       rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            channel_count_reg <= MODE_RESET;
        else if (channel_count_we)
            channel_count_reg <= channel_count_wdata;
    end

    adx_nsc_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .channel_count (channel_count_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .byte_value    (byte_value),
        .rec_valid     (rec_valid),
        .rec           (rec),
        .rec_take      (rec_take)
    );

    adx_nsc_scale u_scale
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_valid     (rec_valid),
        .rec           (rec),
        .rec_take      (rec_take),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample        (sample),
        .channel       (channel),
        .last_in_block (last_in_block)
    );

`ifndef SYNTHESIS
    // a record is released only when one is held
    a_take_needs_rec: assert property (@(posedge clk) disable iff (!rst_n)
        rec_take |-> rec_valid)
        else $error("record released while none is held");

    // releasing a record always puts its second sample on the output
    a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        rec_take |=> out_valid)
        else $error("record released without a result");

    // a restart never leaves a data record behind
    a_restart_no_rec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (op == OP_RESTART)) |=> !rec_valid)
        else $error("record pending after restart");
`endif

endmodule

`default_nettype wire
